// ===== rtl/fcc_pkg.sv =====
// Shared constants, plane table and operation codes for the frustum cube cull block.
package fcc_pkg;

   localparam int MATRIX_DIM   = 4;
   localparam int MATRIX_DEPTH = MATRIX_DIM * MATRIX_DIM;
   localparam int INDEX_WIDTH  = $clog2(MATRIX_DEPTH);
   localparam int PLANE_COUNT  = 6;
   localparam int AXIS_COUNT   = 3;
   localparam int W_ROW        = 3;   // fourth row, also the constant term of a plane
   localparam int FRAC_BITS    = 16;
   localparam int FIELD_WIDTH  = 32;
   localparam int HALF_WIDTH   = 31;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_TEST  = 1'b1
   } op_type;

   // plane p = row3 +/- row PLANE_ROW[p]
   localparam logic [1:0] PLANE_ROW [PLANE_COUNT] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
   localparam logic       PLANE_ADD [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

endpackage

// ===== rtl/fcc_ifs.sv =====
// Request and response channel interfaces of the frustum cube cull block.
interface fcc_req_if;
   logic                                   valid;
   logic                                   ready;
   fcc_pkg::op_type                        operation;
   logic        [fcc_pkg::INDEX_WIDTH-1:0] element_index;
   logic signed [fcc_pkg::FIELD_WIDTH-1:0] element_value;
   logic signed [fcc_pkg::FIELD_WIDTH-1:0] center_x;
   logic signed [fcc_pkg::FIELD_WIDTH-1:0] center_y;
   logic signed [fcc_pkg::FIELD_WIDTH-1:0] center_z;
   logic        [fcc_pkg::HALF_WIDTH-1:0]  half_size;

   modport source (
      output valid, operation, element_index, element_value,
      output center_x, center_y, center_z, half_size,
      input  ready
   );
   modport sink (
      input  valid, operation, element_index, element_value,
      input  center_x, center_y, center_z, half_size,
      output ready
   );
endinterface

interface fcc_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

// ===== rtl/fcc_plane_store.sv =====
// Clip matrix registers and the six registered frustum plane coefficient sets.
module fcc_plane_store #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic        [fcc_pkg::INDEX_WIDTH-1:0] wr_index,
   input  logic signed [VALUE_WIDTH-1:0]          wr_value,
   output logic signed [VALUE_WIDTH:0]            plane_coef
                                                  [fcc_pkg::PLANE_COUNT][fcc_pkg::MATRIX_DIM]
);
   import fcc_pkg::*;

   logic signed [VALUE_WIDTH-1:0] matrix_ff [MATRIX_DEPTH];
   logic signed [VALUE_WIDTH:0]   plane_in  [PLANE_COUNT][MATRIX_DIM];
   logic signed [VALUE_WIDTH:0]   plane_ff  [PLANE_COUNT][MATRIX_DIM];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MATRIX_DEPTH; i++) begin
            matrix_ff[i] <= '0;
         end
      end else if (wr_en) begin
         matrix_ff[wr_index] <= wr_value;
      end
   end

   // column-major: element of row r, column c sits at c*4+r
   always_comb begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
         for (int j = 0; j < MATRIX_DIM; j++) begin
            if (PLANE_ADD[p]) begin
               plane_in[p][j] =
                  {matrix_ff[j*MATRIX_DIM + W_ROW][VALUE_WIDTH-1],
                   matrix_ff[j*MATRIX_DIM + W_ROW]}
                + {matrix_ff[j*MATRIX_DIM + int'(PLANE_ROW[p])][VALUE_WIDTH-1],
                   matrix_ff[j*MATRIX_DIM + int'(PLANE_ROW[p])]};
            end else begin
               plane_in[p][j] =
                  {matrix_ff[j*MATRIX_DIM + W_ROW][VALUE_WIDTH-1],
                   matrix_ff[j*MATRIX_DIM + W_ROW]}
                - {matrix_ff[j*MATRIX_DIM + int'(PLANE_ROW[p])][VALUE_WIDTH-1],
                   matrix_ff[j*MATRIX_DIM + int'(PLANE_ROW[p])]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
   end

   assign plane_coef = plane_ff;

endmodule

// ===== rtl/fcc_plane_eval.sv =====
// One plane: picks the farthest corner per axis, multiplies, then signs the distance.
module fcc_plane_eval #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       advance,
   input  logic signed [VALUE_WIDTH:0] coef      [fcc_pkg::MATRIX_DIM],
   input  logic signed [VALUE_WIDTH:0] corner_lo [fcc_pkg::AXIS_COUNT],
   input  logic signed [VALUE_WIDTH:0] corner_hi [fcc_pkg::AXIS_COUNT],
   output logic                       positive
);
   import fcc_pkg::*;

   localparam int PROD_WIDTH  = 2 * VALUE_WIDTH + 2;
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   localparam int SHIFT_WIDTH = VALUE_WIDTH + 1 + FRAC_BITS;

   logic signed [VALUE_WIDTH:0]   pick    [AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0]  prod_in [AXIS_COUNT];
   logic signed [PROD_WIDTH-1:0]  prod_ff [AXIS_COUNT];
   logic signed [SHIFT_WIDTH-1:0] dist_shift;
   logic signed [SUM_WIDTH-1:0]   dist_in;
   logic signed [SUM_WIDTH-1:0]   dist_ff;
   logic signed [SUM_WIDTH-1:0]   sum;

   // the corner with the largest distance takes the high side where the coefficient is
   // not negative
   always_comb begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
         pick[a]    = coef[a][VALUE_WIDTH] ? corner_lo[a] : corner_hi[a];
         prod_in[a] = coef[a] * pick[a];
      end
   end

   assign dist_shift = {coef[W_ROW], {FRAC_BITS{1'b0}}};
   assign dist_in    = SUM_WIDTH'(dist_shift);

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         dist_ff <= dist_in;
      end
   end

   assign sum = dist_ff + SUM_WIDTH'(prod_ff[0]) + SUM_WIDTH'(prod_ff[1])
              + SUM_WIDTH'(prod_ff[2]);

   assign positive = !sum[SUM_WIDTH-1] && (sum != '0);

endmodule

// ===== rtl/frustum_cube_cull_top.sv =====
// Frustum cube cull: clip matrix store, six parallel plane tests and result register.
// Pipeline: a test item passes the corner register, product register and result register
//   in that order; eighteen plane multipliers work in parallel.
// Throughput: one item per cycle unless a waiting result stalls the pipe; set by those multipliers.
// Matrix writes give no result and take effect for every test taken after them.
// Reset: synchronous; clears the matrix to zero and all valid flags; ready is low in reset.
module frustum_cube_cull_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   fcc_req_if.sink    req_if,
   fcc_rsp_if.source  rsp_if
);
   import fcc_pkg::*;

   // pipeline control: one global enable, the whole pipe moves unless the result
   // register is full and not being taken
   logic advance;
   logic accept;
   logic test_in;
   logic wr_en;

   // input conversion to the working value width
   logic signed [VALUE_WIDTH-1:0] wr_value;
   logic        [VALUE_WIDTH-2:0] half_val;
   logic signed [VALUE_WIDTH:0]   half_ext;
   logic signed [VALUE_WIDTH-1:0] cen      [AXIS_COUNT];
   logic signed [VALUE_WIDTH:0]   cen_ext  [AXIS_COUNT];

   // stage 1: cube corners
   logic                        s1_valid_in;
   logic                        s1_valid_ff;
   logic signed [VALUE_WIDTH:0] corner_lo_in [AXIS_COUNT];
   logic signed [VALUE_WIDTH:0] corner_hi_in [AXIS_COUNT];
   logic signed [VALUE_WIDTH:0] corner_lo_ff [AXIS_COUNT];
   logic signed [VALUE_WIDTH:0] corner_hi_ff [AXIS_COUNT];

   // stage 2: products live inside the plane units
   logic s2_valid_ff;

   // result register
   logic rsp_valid_ff;
   logic inside_in;
   logic inside_ff;

   logic signed [VALUE_WIDTH:0] plane_coef [PLANE_COUNT][MATRIX_DIM];
   logic [PLANE_COUNT-1:0]      plane_pos;

   assign advance       = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = advance && !reset;
   assign accept        = req_if.valid && req_if.ready;
   assign test_in       = (req_if.operation == OP_TEST);
   assign wr_en         = accept && (req_if.operation == OP_WRITE);
   assign s1_valid_in   = accept && test_in;

   // wrap or sign-extend the 32-bit fields to the working width
   assign wr_value = VALUE_WIDTH'(req_if.element_value);
   assign half_val = (VALUE_WIDTH-1)'(req_if.half_size);
   assign half_ext = {2'b00, half_val};
   assign cen[0]   = VALUE_WIDTH'(req_if.center_x);
   assign cen[1]   = VALUE_WIDTH'(req_if.center_y);
   assign cen[2]   = VALUE_WIDTH'(req_if.center_z);

   // one extra bit holds centre +/- half size without wrap
   always_comb begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
         cen_ext[a]      = {cen[a][VALUE_WIDTH-1], cen[a]};
         corner_lo_in[a] = cen_ext[a] - half_ext;
         corner_hi_in[a] = cen_ext[a] + half_ext;
      end
   end

   fcc_plane_store #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_index   (req_if.element_index),
      .wr_value   (wr_value),
      .plane_coef (plane_coef)
   );

   // cube is outside as soon as one plane sees no corner in front of it
   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
      fcc_plane_eval #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_eval (
         .clock     (clock),
         .advance   (advance),
         .coef      (plane_coef[p]),
         .corner_lo (corner_lo_ff),
         .corner_hi (corner_hi_ff),
         .positive  (plane_pos[p])
      );
   end

   assign inside_in = &plane_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         corner_lo_ff <= corner_lo_in;
         corner_hi_ff <= corner_hi_in;
      end
      if (advance) begin
         inside_ff <= inside_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.inside_res = inside_ff;

endmodule
